/* rtl/lcdt_pkg.sv */
package lcdt_pkg;

  localparam int COUNT_W          = 32;
  localparam int SCALE_W          = 20;
  localparam int Q_SHIFT          = 16;
  localparam int TARE_SAMPLES_DEF = 100;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd49346;

  localparam logic [3:0] TAG_FIRST = 4'd0;
  localparam logic [3:0] TAG_LAST  = 4'd7;

  localparam logic [COUNT_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [COUNT_W-1:0] FORCE_MIN = 32'h8000_0000;

  // Status of the tare mean divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* rtl/lcdt_div.sv */
module lcdt_div import lcdt_pkg::*; #(
  parameter int TARE_SAMPLES = TARE_SAMPLES_DEF,
  parameter int SUM_W        = 33 + $clog2(TARE_SAMPLES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   sum,
  output div_status_t               status,
  output logic signed [COUNT_W-1:0] mean
);

  // Mean by reciprocal multiply: q = floor(mag * RECIP / 2^SHIFT), exact for any
  // mag below 2^SUM_W with RECIP = ceil(2^SHIFT / TARE_SAMPLES).
  localparam int CHUNK_W = 16;
  localparam int NCH     = (SUM_W + CHUNK_W - 1) / CHUNK_W;
  localparam int MQ_W    = NCH * CHUNK_W;
  localparam int RW      = SUM_W + 1;
  localparam int ACC_W   = CHUNK_W + RW;
  localparam int SHIFT   = SUM_W + $clog2(TARE_SAMPLES);
  localparam int FS      = SHIFT - CHUNK_W * (NCH - 1);
  localparam int CNT_W   = $clog2(NCH + 1);

  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES);
  localparam logic [RW-1:0] RECIP = RW'(RECIP64);

  logic [CNT_W-1:0] cnt;
  logic [MQ_W-1:0]  mq;
  logic [ACC_W-1:0] acc;
  logic             neg;
  logic             busy;
  logic             done;

  logic [SUM_W-1:0]   mag;
  logic [ACC_W-1:0]   part;
  logic [COUNT_W-1:0] quo;

  // Work on the magnitude, restore the sign at the end (truncate toward zero).
  assign mag  = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  // 16-bit slice of the magnitude times the reciprocal
  assign part = ACC_W'(mq[CHUNK_W-1:0]) * ACC_W'(RECIP);
  assign quo  = acc[FS +: COUNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NCH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Low slice first; dropping the low product bits each step keeps the floor exact.
  always_ff @(posedge clk) begin
    if (start) begin
      mq  <= MQ_W'(mag);
      acc <= '0;
      neg <= sum[SUM_W-1];
    end else if (busy) begin
      mq  <= mq >> CHUNK_W;
      acc <= (acc >> CHUNK_W) + part;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign mean        = neg ? (~quo + 1'b1) : quo;

endmodule

/* rtl/load_cell_nibble_deframe_tare_top.sv */
// Channel   | Dir | Signals                       | Payload (low bit first)
// ----------+-----+-------------------------------+-------------------------------------
// config    | in  | cfg_we, cfg_data[19:0]        | scale (Q16 millinewtons per count)
// s_axis    | in  | tvalid, tready, tdata[15:0]   | rx_byte[7:0], tare_request[8]
// m_axis    | out | tvalid, tready, tdata[71:0]   | force_mn, raw_count, saturated,
//           |     |                               | taring, tare_done
//
// One byte per cycle unless a completing byte is held: a byte request enters the input
// register; deframing and tare accumulation act as it leaves, and a completing byte
// lands its 33x21 force multiply with clipping in the result register. A finished tare
// takes its mean by reciprocal multiply, 16 sum bits per cycle, then loads the offset;
// hold a word-completing byte until then. A word needs eight bytes, so a full-rate
// stream never waits on it. Synchronous active-high reset clears framing and tare state
// and restores the default scale. A result waiting on m_axis stalls only a completing byte.
module load_cell_nibble_deframe_tare_top import lcdt_pkg::*; #(
  parameter int TARE_SAMPLES = TARE_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // rx_byte[7:0], tare_request[8], zeros
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata    // force_mn[31:0], raw_count[63:32],
                                             // saturated[64], taring[65],
                                             // tare_done[66], zeros
);

  localparam int SUM_W  = 33 + $clog2(TARE_SAMPLES);
  localparam int SEEN_W = $clog2(TARE_SAMPLES + 1);
  localparam int PROD_W = COUNT_W + 1 + SCALE_W + 1;
  localparam int F_W    = PROD_W - Q_SHIFT;

  // Configuration
  logic [SCALE_W-1:0] scale;

  // Input register
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_req;

  // Framing and tare state
  logic [2:0]                next_slot;
  logic [COUNT_W-1:0]        word_shift;
  logic                      tare_active;
  logic [SEEN_W-1:0]         tare_seen;
  logic signed [SUM_W-1:0]   tare_sum;
  logic signed [COUNT_W-1:0] tare_offset;

  // Result register
  logic               out_valid;
  logic [COUNT_W-1:0] out_force;
  logic [COUNT_W-1:0] out_raw;
  logic               out_sat;
  logic               out_taring;
  logic               out_done;

  // Processing of the byte in the input register
  logic [3:0]                tag;
  logic [3:0]                nib;
  logic                      req_take;
  logic                      act_pre;
  logic                      in_order;
  logic                      completes;
  logic [COUNT_W-1:0]        word_fill;
  logic signed [COUNT_W-1:0] count;
  logic signed [COUNT_W:0]   diff;
  logic signed [SCALE_W:0]   scale_s;
  logic signed [PROD_W-1:0]  prod;
  logic [F_W-1:0]            f_full;
  logic                      sat;
  logic [COUNT_W-1:0]        force_sat;
  logic [SEEN_W-1:0]         seen_inc;
  logic signed [SUM_W-1:0]   sum_add;
  logic                      finish;
  logic                      out_free;
  logic                      advance;
  logic                      emit;
  logic                      div_start;
  logic                      div_pending;

  div_status_t               div_status;
  logic signed [COUNT_W-1:0] div_mean;

  assign tag      = a_byte[7:4];
  assign nib      = a_byte[3:0];
  assign req_take = a_req && !tare_active;
  assign act_pre  = tare_active || a_req;

  assign in_order  = (tag == {1'b0, next_slot});
  assign completes = in_order && (tag == TAG_LAST);
  assign word_fill = word_shift | (COUNT_W'(nib) << {tag[2:0], 2'b00});
  assign count     = signed'(word_fill);

  // Force: floor((count - tare) * scale / 2^16), clipped to 32 bits
  assign diff    = {count[COUNT_W-1], count} - {tare_offset[COUNT_W-1], tare_offset};
  assign scale_s = signed'({1'b0, scale});
  assign prod    = diff * scale_s;
  assign f_full  = prod[PROD_W-1:Q_SHIFT];
  assign sat     = !((&f_full[F_W-1:COUNT_W-1]) || !(|f_full[F_W-1:COUNT_W-1]));
  assign force_sat = sat ? (f_full[F_W-1] ? FORCE_MIN : FORCE_MAX) : f_full[COUNT_W-1:0];

  // Tare accumulation, restarting on a fresh request
  assign seen_inc = (req_take ? '0 : tare_seen) + 1'b1;
  assign sum_add  = (req_take ? '0 : tare_sum) + {{(SUM_W-COUNT_W){count[COUNT_W-1]}}, count};
  assign finish   = act_pre && (seen_inc == SEEN_W'(TARE_SAMPLES));

  // Hold a completing byte while the result slot is full or a new tare is pending
  assign div_pending = div_status.busy || div_status.done;
  assign out_free    = !out_valid || m_axis_tready;
  assign advance     = a_valid && (!completes || (out_free && !div_pending));
  assign emit        = advance && completes;
  assign div_start   = emit && finish;

  assign s_axis_tready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_byte <= s_axis_tdata[7:0];
      a_req  <= s_axis_tdata[8];
    end
  end

  // Framing and tare state update
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot   <= '0;
      word_shift  <= '0;
      tare_active <= 1'b0;
      tare_seen   <= '0;
      tare_sum    <= '0;
      tare_offset <= '0;
    end else begin
      if (div_status.done) begin
        tare_offset <= div_mean;
      end
      if (advance) begin
        priority if (tag == TAG_FIRST) begin
          word_shift <= COUNT_W'(nib);
          next_slot  <= 3'd1;
        end else if (!in_order) begin
          // drop the partial word and the byte
          word_shift <= '0;
          next_slot  <= '0;
        end else if (!completes) begin
          word_shift <= word_fill;
          next_slot  <= next_slot + 1'b1;
        end else begin
          word_shift <= '0;
          next_slot  <= '0;
        end
        // A request counts from this step; a completed word feeds a running tare
        if (completes && act_pre) begin
          tare_active <= !finish;
          tare_seen   <= finish ? '0 : seen_inc;
          tare_sum    <= finish ? '0 : sum_add;
        end else if (req_take) begin
          tare_active <= 1'b1;
          tare_seen   <= '0;
          tare_sum    <= '0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_force  <= force_sat;
      out_raw    <= word_fill;
      out_sat    <= sat;
      out_taring <= act_pre && !finish;
      out_done   <= finish;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_done, out_taring, out_sat, out_raw, out_force};

  lcdt_div #(
    .TARE_SAMPLES(TARE_SAMPLES),
    .SUM_W       (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (sum_add),
    .status(div_status),
    .mean  (div_mean)
  );

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_pending)
    else $error("tare divider restarted while busy");

  a_offset_load: assert property (@(posedge clk) disable iff (rst)
    div_status.done |=> tare_offset == $past(div_mean))
    else $error("tare offset not loaded from divider");

  a_idle_tare_clear: assert property (@(posedge clk) disable iff (rst)
    !tare_active |-> (tare_seen == '0) && (tare_sum == '0))
    else $error("tare accumulator not clear while idle");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    tare_seen < SEEN_W'(TARE_SAMPLES))
    else $error("tare sample count out of range");

  a_done_ends_taring: assert property (@(posedge clk) disable iff (rst)
    emit && finish |=> !tare_active && out_done && !out_taring)
    else $error("tare finish not reflected in state and result");

endmodule
